@@ rtl/tmhc_pkg.sv @@
// ----------------------------------------------------------------------------
// tmhc_pkg
// Shared types and constants for the temperature / humidity compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package tmhc_pkg;

  // pipeline depth: three temperature stages, seven humidity stages
  localparam int NSTAGE      = 10;
  localparam int TEMP_STAGES = 3;
  localparam int HUM_STAGES  = NSTAGE - TEMP_STAGES;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 80;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_CAL_ONE   = 3'd0,
    REG_TEMP_CAL_TWO   = 3'd1,
    REG_TEMP_CAL_THREE = 3'd2,
    REG_HUM_CAL_BYTES  = 3'd3,
    REG_HUM_CAL_TWO    = 3'd4,
    REG_HUM_CAL_FOUR   = 3'd5,
    REG_HUM_CAL_FIVE   = 3'd6
  } reg_idx_t;

  // calibration set as seen by the datapaths
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [7:0]  h1;
    logic [7:0]  h3;
    logic [7:0]  h6;
    logic [15:0] h2;
    logic [11:0] h4;
    logic [11:0] h5;
  } cal_t;

  localparam logic [31:0] HUM_T_OFFSET = 32'd76800;
  localparam logic [31:0] HUM_A_ROUND  = 32'd16384;
  localparam logic [31:0] HUM_C_BIAS   = 32'd32768;
  localparam logic [31:0] HUM_D_BIAS   = 32'd2097152;
  localparam logic [31:0] HUM_E_ROUND  = 32'd8192;
  localparam logic [31:0] HUM_MAX      = 32'd419430400;
  localparam logic [26:0] CENTI_ROUND  = 27'd128;

endpackage

`default_nettype wire

@@ rtl/temp_humidity_compensation_top.sv @@
// ----------------------------------------------------------------------------
// temp_humidity_compensation_top
// Integer compensation of raw temperature and humidity sensor readings.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle while out_tready does not hold the output;
//   ten register stages, the humidity chain of six dependent multiplies, one
//   per stage, sets the depth
// reset: synchronous active-low rst_n clears all valid bits and all
//   calibration registers to zero; datapath registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module temp_humidity_compensation_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [19:0] raw_temperature, [35:20] raw_humidity, [39:36] zero
  input  wire logic [tmhc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [31:0] fine_temperature, [58:32] temperature_centi,
  // [75:59] humidity_q10, [79:76] zero
  output logic [tmhc_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // calibration write port
  input  wire logic                              cfg_wr_en,
  input  wire logic [tmhc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tmhc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tmhc_pkg::*;

  cal_t               cal;
  logic [NSTAGE-1:0]  stage_en;
  logic signed [23:0] tf;
  logic [15:0]        adc_h;
  logic [31:0]        fine_temperature;
  logic [26:0]        temperature_centi;
  logic [16:0]        humidity_q10;

  // calibration registers; write them only while the pipeline is empty (not enforced here)
  tmhc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  // valid bits per stage; a stage loads when empty or when it drains,
  // so bubbles close up while the output beat waits
  tmhc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stage_en  (stage_en)
  );

  // stages 1..3: fine temperature
  tmhc_temp u_temp (
    .clk             (clk),
    .en              (stage_en[TEMP_STAGES-1:0]),
    .cal             (cal),
    .raw_temperature (in_tdata[19:0]),
    .raw_humidity    (in_tdata[35:20]),
    .tf              (tf),
    .adc_h           (adc_h)
  );

  // stages 4..10: humidity chain and temperature scaling, last stage is the
  // output register
  tmhc_hum u_hum (
    .clk               (clk),
    .en                (stage_en[NSTAGE-1:TEMP_STAGES]),
    .cal               (cal),
    .tf                (tf),
    .adc_h             (adc_h),
    .fine_temperature  (fine_temperature),
    .temperature_centi (temperature_centi),
    .humidity_q10      (humidity_q10)
  );

  assign out_tdata = {4'b0, humidity_q10, temperature_centi, fine_temperature};

endmodule

`default_nettype wire

@@ rtl/tmhc_cfg.sv @@
// ----------------------------------------------------------------------------
// tmhc_cfg
// Calibration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module tmhc_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [tmhc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tmhc_pkg::CFG_DATA_W-1:0] cfg_data,
  output tmhc_pkg::cal_t                      cal
);
  import tmhc_pkg::*;

  cal_t cal_r;
  cal_t cal_nxt;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TEMP_CAL_ONE:   cal_nxt.t1 = cfg_data[15:0];
        REG_TEMP_CAL_TWO:   cal_nxt.t2 = cfg_data[15:0];
        REG_TEMP_CAL_THREE: cal_nxt.t3 = cfg_data[15:0];
        REG_HUM_CAL_BYTES: begin
          cal_nxt.h1 = cfg_data[7:0];
          cal_nxt.h3 = cfg_data[15:8];
          cal_nxt.h6 = cfg_data[23:16];
        end
        REG_HUM_CAL_TWO:    cal_nxt.h2 = cfg_data[15:0];
        REG_HUM_CAL_FOUR:   cal_nxt.h4 = cfg_data[11:0];
        REG_HUM_CAL_FIVE:   cal_nxt.h5 = cfg_data[11:0];
        default:            cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  assign cal = cal_r;

endmodule

`default_nettype wire

@@ rtl/tmhc_ctrl.sv @@
// ----------------------------------------------------------------------------
// tmhc_ctrl
// Valid bits and per-stage load enables for the elastic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tmhc_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [tmhc_pkg::NSTAGE-1:0]      stage_en
);
  import tmhc_pkg::*;

  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] vld_nxt;
  logic [NSTAGE-1:0] ready;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    ready[NSTAGE-1] = !vld_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      ready[k] = !vld_r[k] || ready[k+1];
    end
  end

  always_comb begin
    vld_nxt[0] = ready[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      vld_nxt[k] = ready[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign stage_en  = ready;
  assign in_ready  = ready[0];
  assign out_valid = vld_r[NSTAGE-1];

endmodule

`default_nettype wire

@@ rtl/tmhc_temp.sv @@
// ----------------------------------------------------------------------------
// tmhc_temp
// Fine temperature pipeline: linear and square terms, then their sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tmhc_temp (
  input  wire logic                              clk,
  input  wire logic [tmhc_pkg::TEMP_STAGES-1:0]  en,
  input  wire tmhc_pkg::cal_t                    cal,
  input  wire logic [19:0]                       raw_temperature,
  input  wire logic [15:0]                       raw_humidity,
  output logic signed [23:0]                     tf,
  output logic [15:0]                            adc_h
);
  import tmhc_pkg::*;

  // stage 1: raw products
  logic signed [17:0] lin_diff;
  logic signed [16:0] sq_diff;
  logic signed [33:0] sq_full;
  logic signed [33:0] prod_lin_r;
  logic [32:0]        dif_sq_r;
  logic [15:0]        adc_h1_r;

  // stage 2: scaled linear term, square times gain
  logic signed [37:0] prod_sq_nxt;
  logic signed [22:0] lin_r;
  logic signed [37:0] prod_sq_r;
  logic [15:0]        adc_h2_r;

  // stage 3: fine temperature
  logic signed [23:0] tf_nxt;
  logic signed [23:0] tf_r;
  logic [15:0]        adc_h3_r;

  assign lin_diff = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
  assign sq_diff  = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cal.t1});
  assign sq_full  = sq_diff * sq_diff;

  assign prod_sq_nxt = $signed({1'b0, dif_sq_r[32:12]}) * $signed(cal.t3);
  assign tf_nxt      = $signed({lin_r[22], lin_r}) + $signed(prod_sq_r[37:14]);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_lin_r <= lin_diff * $signed(cal.t2);
      dif_sq_r   <= sq_full[32:0];
      adc_h1_r   <= raw_humidity;
    end
    if (en[1]) begin
      lin_r     <= prod_lin_r[33:11];
      prod_sq_r <= prod_sq_nxt;
      adc_h2_r  <= adc_h1_r;
    end
    if (en[2]) begin
      tf_r     <= tf_nxt;
      adc_h3_r <= adc_h2_r;
    end
  end

  assign tf    = tf_r;
  assign adc_h = adc_h3_r;

endmodule

`default_nettype wire

@@ rtl/tmhc_hum.sv @@
// ----------------------------------------------------------------------------
// tmhc_hum
// Humidity pipeline with 32-bit wrapping arithmetic and a chain of dependent multiplies;
// also scales the fine temperature to hundredths and carries it along.
// ----------------------------------------------------------------------------
`default_nettype none

module tmhc_hum (
  input  wire logic                             clk,
  input  wire logic [tmhc_pkg::HUM_STAGES-1:0]  en,
  input  wire tmhc_pkg::cal_t                   cal,
  input  wire logic signed [23:0]               tf,
  input  wire logic [15:0]                      adc_h,
  output logic [31:0]                           fine_temperature,
  output logic [26:0]                           temperature_centi,
  output logic [16:0]                           humidity_q10
);
  import tmhc_pkg::*;

  localparam int LAST = HUM_STAGES - 1;

  // carried temperature results
  logic signed [23:0] tf_r    [HUM_STAGES];
  logic signed [18:0] centi_r [HUM_STAGES];

  // stage a: offset temperature and first products
  logic [31:0]        tv;
  logic signed [26:0] t5;
  logic [31:0]        base_r, p_h5_r, p_h6_r, p_h3_r;

  // stage b
  logic [31:0] a_sum, a_val, b_val, c_val;
  logic [31:0] a_b_r, p_bc_r;

  // stage c
  logic [31:0] d_val;
  logic [31:0] a_c_r, p_dh2_r;

  // stage d
  logic [31:0] e_sum, e_val;
  logic [31:0] v_d_r;

  // stage e
  logic [31:0] s_val;
  logic [31:0] v_e_r, p_ss_r;

  // stage f
  logic [31:0] f_val;
  logic [31:0] v_f_r, p_fh1_r;

  // stage g: subtract and clamp
  logic [31:0] g_val, v_diff, v_clamp;
  logic [16:0] hum_r;

  assign tv = {{8{tf[23]}}, tf} - HUM_T_OFFSET;
  assign t5 = $signed({tf[23], tf, 2'b00}) + $signed({{3{tf[23]}}, tf}) + $signed(CENTI_ROUND);

  assign a_sum = base_r - p_h5_r + HUM_A_ROUND;
  assign a_val = {{15{a_sum[31]}}, a_sum[31:15]};
  assign b_val = {{10{p_h6_r[31]}}, p_h6_r[31:10]};
  assign c_val = {{11{p_h3_r[31]}}, p_h3_r[31:11]} + HUM_C_BIAS;

  assign d_val = {{10{p_bc_r[31]}}, p_bc_r[31:10]} + HUM_D_BIAS;

  assign e_sum = p_dh2_r + HUM_E_ROUND;
  assign e_val = {{14{e_sum[31]}}, e_sum[31:14]};

  assign s_val = {{15{v_d_r[31]}}, v_d_r[31:15]};
  assign f_val = {{7{p_ss_r[31]}}, p_ss_r[31:7]};

  assign g_val  = {{4{p_fh1_r[31]}}, p_fh1_r[31:4]};
  assign v_diff = v_f_r - g_val;

  // negative clamps to zero, above full scale clamps to full scale
  always_comb begin
    priority if (v_diff[31]) begin
      v_clamp = '0;
    end else if (v_diff > HUM_MAX) begin
      v_clamp = HUM_MAX;
    end else begin
      v_clamp = v_diff;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tf_r[0]    <= tf;
      centi_r[0] <= t5[26:8];
      base_r     <= {2'b00, adc_h, 14'b0} - {cal.h4, 20'b0};
      p_h5_r     <= tv * {{20{cal.h5[11]}}, cal.h5};
      p_h6_r     <= tv * {{24{cal.h6[7]}}, cal.h6};
      p_h3_r     <= tv * {24'b0, cal.h3};
    end
    for (int k = 1; k < HUM_STAGES; k++) begin
      if (en[k]) begin
        tf_r[k]    <= tf_r[k-1];
        centi_r[k] <= centi_r[k-1];
      end
    end
    if (en[1]) begin
      a_b_r  <= a_val;
      p_bc_r <= b_val * c_val;
    end
    if (en[2]) begin
      a_c_r   <= a_b_r;
      p_dh2_r <= d_val * {{16{cal.h2[15]}}, cal.h2};
    end
    if (en[3]) begin
      v_d_r <= a_c_r * e_val;
    end
    if (en[4]) begin
      v_e_r  <= v_d_r;
      p_ss_r <= s_val * s_val;
    end
    if (en[5]) begin
      v_f_r   <= v_e_r;
      p_fh1_r <= f_val * {24'b0, cal.h1};
    end
    if (en[6]) begin
      hum_r <= v_clamp[28:12];
    end
  end

  assign fine_temperature  = {{8{tf_r[LAST][23]}}, tf_r[LAST]};
  assign temperature_centi = {{8{centi_r[LAST][18]}}, centi_r[LAST]};
  assign humidity_q10      = hum_r;

endmodule

`default_nettype wire
